/* sv/nia_pkg.sv */
// ----------------------------------------------------------------------------
// nia_pkg
// Shared types, operation codes and helpers for the nullable integer ALU.
// ----------------------------------------------------------------------------
package nia_pkg;

    localparam int DataW = 64;
    localparam int KindW = 4;
    localparam int WcW   = 2;

    localparam logic [KindW-1:0] KIND_ADD = 4'd0;
    localparam logic [KindW-1:0] KIND_SUB = 4'd1;
    localparam logic [KindW-1:0] KIND_MUL = 4'd2;
    localparam logic [KindW-1:0] KIND_DIV = 4'd3;
    localparam logic [KindW-1:0] KIND_MOD = 4'd4;
    localparam logic [KindW-1:0] KIND_AND = 4'd5;
    localparam logic [KindW-1:0] KIND_XOR = 4'd6;
    localparam logic [KindW-1:0] KIND_OR  = 4'd7;
    localparam logic [KindW-1:0] KIND_NOT = 4'd8;
    localparam logic [KindW-1:0] KIND_EQ  = 4'd9;
    localparam logic [KindW-1:0] KIND_NE  = 4'd10;
    localparam logic [KindW-1:0] KIND_GT  = 4'd11;
    localparam logic [KindW-1:0] KIND_LT  = 4'd12;
    localparam logic [KindW-1:0] KIND_GE  = 4'd13;
    localparam logic [KindW-1:0] KIND_LE  = 4'd14;

    localparam logic [WcW-1:0] WC_8  = 2'd0;
    localparam logic [WcW-1:0] WC_16 = 2'd1;
    localparam logic [WcW-1:0] WC_32 = 2'd2;
    localparam logic [WcW-1:0] WC_64 = 2'd3;

    // word in flight through the divider stages
    typedef struct packed {
        logic             valid;
        logic             is_null;
        logic [KindW-1:0] kind;
        logic [WcW-1:0]   wcode;
        logic             a_neg;
        logic             b_neg;
        logic [DataW-1:0] res;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dq;   // dividend shifting out, quotient shifting in
        logic [DataW-1:0] dsr;
    } pipe_t;

    function automatic logic [DataW-1:0] sext_w(input logic [DataW-1:0] v,
                                                input logic [WcW-1:0] wc);
        logic [DataW-1:0] r;
        begin
            case (wc)
                WC_8:    r = {{(DataW-8){v[7]}}, v[7:0]};
                WC_16:   r = {{(DataW-16){v[15]}}, v[15:0]};
                WC_32:   r = {{(DataW-32){v[31]}}, v[31:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

/* sv/nia_div_step.sv */
// ----------------------------------------------------------------------------
// nia_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module nia_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  nia_pkg::pipe_t d_in,
    output nia_pkg::pipe_t d_out
);
    import nia_pkg::*;

    logic [DataW-1:0] sh;
    logic             ge;
    pipe_t            step_next;

    always_comb
    begin
        sh        = {d_in.rem[DataW-2:0], d_in.dq[DataW-1]};
        ge        = (sh >= d_in.dsr);
        step_next = d_in;
        step_next.rem = ge ? (sh - d_in.dsr) : sh;
        step_next.dq  = {d_in.dq[DataW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_out.valid <= 1'b0;
        end
        else if (adv)
        begin
            d_out <= step_next;
        end
    end

endmodule

/* sv/nullable_integer_alu.sv */
// ----------------------------------------------------------------------------
// nullable_integer_alu
// Nullable signed integer ALU for 8/16/32/64-bit operands.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not held and gives one result
// word per word, in order. Stages: operand prep, multiply partial products,
// product sum, 64 divider stages (one quotient bit each, set by the 64-bit
// divide) and the output register. Every word passes through the divider
// stages so all operations keep the same latency. The pipeline holds while
// the output word waits, so ready follows out_ready when a result is pending.
module nullable_integer_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [nia_pkg::KindW-1:0]  kind,
    input  logic [nia_pkg::WcW-1:0]    width_code,
    input  logic                       a_is_null,
    input  logic signed [nia_pkg::DataW-1:0] a_value,
    input  logic                       b_is_null,
    input  logic signed [nia_pkg::DataW-1:0] b_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_is_null,
    output logic signed [nia_pkg::DataW-1:0] result_value
);
    import nia_pkg::*;

    localparam int NSteps = DataW;

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: sign extension and null detection
    logic             s1_valid_reg;
    logic             s1_null_reg;
    logic [KindW-1:0] s1_kind_reg;
    logic [WcW-1:0]   s1_wc_reg;
    logic [DataW-1:0] s1_a_reg, s1_b_reg;
    logic [DataW-1:0] a_next, b_next;
    logic             null_next;

    always_comb
    begin
        a_next    = sext_w(a_value, width_code);
        b_next    = sext_w(b_value, width_code);
        null_next = (kind == KIND_NOT) ? a_is_null : (a_is_null || b_is_null);
        if ((kind == KIND_DIV || kind == KIND_MOD) && b_next == '0)
            null_next = 1'b1;
        if (kind > KIND_LE)
            null_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s1_null_reg  <= null_next;
            s1_kind_reg  <= kind;
            s1_wc_reg    <= width_code;
            s1_a_reg     <= a_next;
            s1_b_reg     <= b_next;
        end
    end

    // stage 2: simple ops, partial products, magnitudes
    logic             s2_valid_reg;
    logic             s2_null_reg;
    logic [KindW-1:0] s2_kind_reg;
    logic [WcW-1:0]   s2_wc_reg;
    logic             s2_aneg_reg, s2_bneg_reg;
    logic [DataW-1:0] s2_res_reg;
    logic [DataW-1:0] s2_pll_reg;
    logic [31:0]      s2_plh_reg, s2_phl_reg;
    logic [DataW-1:0] s2_ma_reg, s2_mb_reg;
    logic [DataW-1:0] simple_next;
    logic             lt_ab, lt_ba;

    always_comb
    begin
        lt_ab = $signed(s1_a_reg) < $signed(s1_b_reg);
        lt_ba = $signed(s1_b_reg) < $signed(s1_a_reg);
        case (s1_kind_reg)
            KIND_ADD: simple_next = s1_a_reg + s1_b_reg;
            KIND_SUB: simple_next = s1_a_reg - s1_b_reg;
            KIND_AND: simple_next = s1_a_reg & s1_b_reg;
            KIND_XOR: simple_next = s1_a_reg ^ s1_b_reg;
            KIND_OR:  simple_next = s1_a_reg | s1_b_reg;
            KIND_NOT: simple_next = ~s1_a_reg;
            KIND_EQ:  simple_next = {{(DataW-1){1'b0}}, s1_a_reg == s1_b_reg};
            KIND_NE:  simple_next = {{(DataW-1){1'b0}}, s1_a_reg != s1_b_reg};
            KIND_GT:  simple_next = {{(DataW-1){1'b0}}, lt_ba};
            KIND_LT:  simple_next = {{(DataW-1){1'b0}}, lt_ab};
            KIND_GE:  simple_next = {{(DataW-1){1'b0}}, !lt_ab};
            KIND_LE:  simple_next = {{(DataW-1){1'b0}}, !lt_ba};
            default:  simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_null_reg  <= s1_null_reg;
            s2_kind_reg  <= s1_kind_reg;
            s2_wc_reg    <= s1_wc_reg;
            s2_aneg_reg  <= s1_a_reg[DataW-1];
            s2_bneg_reg  <= s1_b_reg[DataW-1];
            s2_res_reg   <= simple_next;
            s2_pll_reg   <= 64'(s1_a_reg[31:0]) * 64'(s1_b_reg[31:0]);
            s2_plh_reg   <= 32'(s1_a_reg[31:0] * s1_b_reg[63:32]);
            s2_phl_reg   <= 32'(s1_a_reg[63:32] * s1_b_reg[31:0]);
            s2_ma_reg    <= s1_a_reg[DataW-1] ? (-s1_a_reg) : s1_a_reg;
            s2_mb_reg    <= s1_b_reg[DataW-1] ? (-s1_b_reg) : s1_b_reg;
        end
    end

    // stage 3: product sum, load divider
    pipe_t            chain [0:NSteps];
    pipe_t            s3_next;
    pipe_t            div_in_reg;
    logic [DataW-1:0] prod;

    always_comb
    begin
        prod = s2_pll_reg + {s2_plh_reg + s2_phl_reg, 32'd0};
        s3_next.valid   = s2_valid_reg;
        s3_next.is_null = s2_null_reg;
        s3_next.kind    = s2_kind_reg;
        s3_next.wcode   = s2_wc_reg;
        s3_next.a_neg   = s2_aneg_reg;
        s3_next.b_neg   = s2_bneg_reg;
        s3_next.res     = (s2_kind_reg == KIND_MUL) ? prod : s2_res_reg;
        s3_next.rem     = '0;
        s3_next.dq      = s2_ma_reg;
        // zero divisor already flagged null; its quotient is never used
        s3_next.dsr     = s2_mb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            div_in_reg <= s3_next;
        end
    end

    assign chain[0] = div_in_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NSteps; gi++)
        begin : g_div
            nia_div_step u_step (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (adv),
                .d_in  (chain[gi]),
                .d_out (chain[gi+1])
            );
        end
    endgenerate

    // output stage: sign fix, width wrap, null clear
    pipe_t            last;
    logic [DataW-1:0] fin;
    logic [DataW-1:0] out_next;
    logic             out_valid_reg;
    logic             out_null_reg;
    logic [DataW-1:0] out_value_reg;

    always_comb
    begin
        last = chain[NSteps];
        case (last.kind)
            KIND_DIV: fin = (last.a_neg != last.b_neg) ? (-last.dq) : last.dq;
            KIND_MOD: fin = last.a_neg ? (-last.rem) : last.rem;
            default:  fin = last.res;
        endcase
        if (last.kind <= KIND_NOT)
            fin = sext_w(fin, last.wcode);
        out_next = last.is_null ? '0 : fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last.valid;
            out_null_reg  <= last.is_null;
            out_value_reg <= out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_is_null = out_null_reg;
    assign result_value   = out_value_reg;

endmodule
